// ===== rtl/core/i2cwrp_pkg.sv =====
// Shared types, codes and constants of the I2C target word register port.
package i2cwrp_pkg;

    // Bus event kinds carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_STOP    = 2'd2,
        CMD_CHANGED = 2'd3
    } cmd_t;

    // Register selector codes.
    localparam logic [7:0] SEL_CHECK   = 8'd1;
    localparam logic [7:0] SEL_RESET   = 8'd2;
    localparam logic [7:0] SEL_INPUTS  = 8'd3;
    localparam logic [7:0] SEL_OUTPUTS = 8'd4;
    localparam logic [7:0] SEL_TEMP    = 8'd5;

    // Error codes reported with each result word.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
    localparam logic [1:0] ERR_OUT_RANGE = 2'd2;

    localparam logic [15:0] CHECK_WORD = 16'h4242;
    localparam logic [7:0]  IDLE_BYTE  = 8'hff;

    // Default number of output channels behind the outputs register.
    localparam int OUTPUT_COUNT_DEF = 16;

    // Transfer state kept between bus events.
    typedef struct packed {
        logic        expect_register;
        logic        xfer_open;
        logic [7:0]  xfer_register;
        logic [1:0]  byte_position;
        logic [15:0] xfer_word;
        logic        intr_asserted;
    } port_state_t;

    // One result word; the last member sits in the lowest bits.
    typedef struct packed {
        logic [1:0] error_code;
        logic [7:0] out_value;
        logic [3:0] out_index;
        logic       out_write;
        logic       reset_pulse;
        logic       intr_level;
        logic [7:0] read_byte;
    } result_t;

endpackage

// ===== rtl/core/i2cwrp_engine.sv =====
// Combinational handling of one bus event against the transfer state.
module i2cwrp_engine
    import i2cwrp_pkg::*;
#(
    parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEF
) (
    input  cmd_t        cmd,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] inputs_now,
    input  logic [15:0] temp_raw,
    input  port_state_t state_cur,
    output port_state_t state_nxt,
    output result_t     result
);

    localparam logic [8:0] OutLimit = 9'(OUTPUT_COUNT);

    logic [1:0] pos_inc;

    assign pos_inc = state_cur.byte_position + 2'd1;

    // Event decode: select, byte transfer, stop and interrupt handling.
    always_comb begin
        port_state_t st;
        result_t     res;
        logic        fin;
        st  = state_cur;
        res = '0;
        res.read_byte = IDLE_BYTE;
        fin = 1'b0;

        unique case (cmd)
            CMD_BYTE: begin
                if (st.expect_register || !st.xfer_open) begin
                    // A register selection opens a new transfer.
                    st.expect_register = 1'b0;
                    st.xfer_open       = 1'b1;
                    st.xfer_register   = rx_byte;
                    st.byte_position   = 2'd0;
                    unique case (rx_byte)
                        SEL_CHECK:   st.xfer_word = CHECK_WORD;
                        SEL_INPUTS:  st.xfer_word = inputs_now;
                        SEL_TEMP:    st.xfer_word = temp_raw;
                        SEL_RESET,
                        SEL_OUTPUTS: st.xfer_word = 16'h0000;
                        default: begin
                            st.xfer_word   = 16'h0000;
                            res.error_code = ERR_UNKNOWN;
                        end
                    endcase
                end else if (st.byte_position < 2'd2) begin
                    // A data byte replaces the byte at the current position.
                    if (st.byte_position == 2'd0) begin
                        st.xfer_word[7:0] = rx_byte;
                    end else begin
                        st.xfer_word[15:8] = rx_byte;
                    end
                    st.byte_position = pos_inc;
                    fin = (pos_inc >= 2'd2);
                end
            end
            CMD_READ: begin
                if (st.xfer_open && st.byte_position < 2'd2) begin
                    res.read_byte    = (st.byte_position == 2'd0) ? st.xfer_word[7:0]
                                                                  : st.xfer_word[15:8];
                    st.byte_position = pos_inc;
                end
                fin = st.xfer_open && (st.byte_position >= 2'd2);
            end
            CMD_STOP: begin
                // A stop drops a transfer that has already moved a byte.
                st.expect_register = 1'b1;
                if (st.xfer_open && st.byte_position != 2'd0) begin
                    st.xfer_open     = 1'b0;
                    st.byte_position = 2'd0;
                    st.xfer_word     = 16'h0000;
                    st.xfer_register = 8'h00;
                end
            end
            CMD_CHANGED: begin
                st.intr_asserted = 1'b1;
            end
        endcase

        // A complete word acts on its register and closes the transfer.
        if (fin) begin
            priority if (st.xfer_register == SEL_INPUTS) begin
                if (inputs_now == st.xfer_word) begin
                    st.intr_asserted = 1'b0;
                end
            end else if (st.xfer_register == SEL_RESET) begin
                res.reset_pulse  = 1'b1;
                st.intr_asserted = 1'b0;
            end else if (st.xfer_register == SEL_OUTPUTS) begin
                if ({1'b0, st.xfer_word[15:8]} >= OutLimit) begin
                    res.error_code = ERR_OUT_RANGE;
                end else begin
                    res.out_write = 1'b1;
                    res.out_index = st.xfer_word[11:8];
                    res.out_value = st.xfer_word[7:0];
                end
            end else begin
                res.out_write = 1'b0;
            end
            st.xfer_open     = 1'b0;
            st.byte_position = 2'd0;
            st.xfer_word     = 16'h0000;
            st.xfer_register = 8'h00;
        end

        res.intr_level = st.intr_asserted;
        state_nxt = st;
        result    = res;
    end

endmodule

// ===== rtl/core/i2c_target_word_register_port.sv =====
// Top level of the I2C target word register port.
//
//  channel | dir | tdata (low bit first)                    | tuser
//  s_      | in  | rx_byte[7:0] inputs_now[23:8] temp[39:24]| cmd[1:0]
//  m_      | out | read_byte intr reset out_write idx val err| -
//
// A bus event accepted into the input register is held there while the decode
// logic works, and its result word is registered in the result register on advance.
// One event is accepted per cycle while the result side keeps taking words.
// A stalled result holds in its register; the input register still takes a word
// only if it is empty, then the input side stalls until the result is taken.
// aresetn (synchronous, active low) clears both valid flags and the transfer
// state; the interrupt line starts released.
module i2c_target_word_register_port
    import i2cwrp_pkg::*;
#(
    parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // rx_byte, inputs_now, temp_raw
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // read_byte, intr_level, reset_pulse, out_write,
                                   // out_index, out_value, error_code
);

    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    logic [7:0]  in_rx_reg;
    logic [15:0] in_inputs_reg;
    logic [15:0] in_temp_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    port_state_t state_reg;
    port_state_t state_next;
    result_t     res_next;
    logic        advance;

    // The decode stage moves when the result register is free or being taken.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_cmd_reg    <= cmd_t'(s_tuser);
            in_rx_reg     <= s_tdata[7:0];
            in_inputs_reg <= s_tdata[23:8];
            in_temp_reg   <= s_tdata[39:24];
        end
    end

    i2cwrp_engine #(
        .OUTPUT_COUNT (OUTPUT_COUNT)
    ) u_engine (
        .cmd        (in_cmd_reg),
        .rx_byte    (in_rx_reg),
        .inputs_now (in_inputs_reg),
        .temp_raw   (in_temp_reg),
        .state_cur  (state_reg),
        .state_nxt  (state_next),
        .result     (res_next)
    );

    // Transfer state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, res_reg};

    // An event leaving the input register always lands in the result register.
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("decoded event did not reach the result register");

    // A closed transfer carries no position and no word.
    a_closed_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.xfer_open |-> (state_reg.byte_position == 2'd0
                                  && state_reg.xfer_word == 16'h0000))
        else $error("closed transfer kept stale position or word");

    // An output write never reports an error.
    a_write_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.out_write) |-> (res_reg.error_code == ERR_NONE))
        else $error("output write reported with an error code");

    // A reset pulse always comes with the interrupt line released.
    a_reset_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.reset_pulse) |-> !res_reg.intr_level)
        else $error("reset pulse left the interrupt asserted");

    // The interrupt level reported matches the stored interrupt state.
    a_intr_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (res_reg.intr_level == state_reg.intr_asserted))
        else $error("reported interrupt level differs from the state");

endmodule

// ===== verif/i2c_target_word_register_port_tb.sv =====
// Self-checking testbench for the I2C target word register port.
module i2c_target_word_register_port_tb
    import i2cwrp_pkg::*;
();

    localparam int OUT_CHANNELS = OUTPUT_COUNT_DEF;
    localparam int RANDOM_TARGET = 480;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // rx_byte, inputs_now, temp_raw
    logic [1:0]  s_tuser = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // read_byte, intr_level, reset_pulse, out_write,
                                 // out_index, out_value, error_code

    // Predicted transfer state and the results still to arrive.
    port_state_t port_model;
    result_t     pending_results[$];

    int mismatch_count = 0;
    int events_sent = 0;
    int cycle_count = 0;

    // Idling controls shared by the sender, the receiver and the tests.
    int  tx_gap_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_request = 1'b0;
    logic [15:0] live_inputs = 16'h0000;

    i2c_target_word_register_port #(
        .OUTPUT_COUNT(OUT_CHANNELS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Works out the result word of one bus event and advances the predicted state.
    function automatic result_t predict_bus_event(cmd_t cmd, logic [7:0] rx,
                                                  logic [15:0] inputs_now,
                                                  logic [15:0] temp_raw);
        result_t res;
        logic    word_done;
        res = '0;
        res.read_byte = IDLE_BYTE;
        word_done = 1'b0;
        case (cmd)
            CMD_BYTE: begin
                if (port_model.expect_register || !port_model.xfer_open) begin
                    // This byte selects a register and opens a transfer.
                    port_model.expect_register = 1'b0;
                    port_model.xfer_open = 1'b1;
                    port_model.xfer_register = rx;
                    port_model.byte_position = 2'd0;
                    case (rx)
                        SEL_CHECK:   port_model.xfer_word = CHECK_WORD;
                        SEL_INPUTS:  port_model.xfer_word = inputs_now;
                        SEL_TEMP:    port_model.xfer_word = temp_raw;
                        SEL_RESET,
                        SEL_OUTPUTS: port_model.xfer_word = 16'h0000;
                        default: begin
                            port_model.xfer_word = 16'h0000;
                            res.error_code = ERR_UNKNOWN;
                        end
                    endcase
                end else if (port_model.byte_position < 2) begin
                    if (port_model.byte_position == 0) begin
                        port_model.xfer_word[7:0] = rx;
                    end else begin
                        port_model.xfer_word[15:8] = rx;
                    end
                    port_model.byte_position = port_model.byte_position + 2'd1;
                    word_done = (port_model.byte_position == 2);
                end
            end
            CMD_READ: begin
                if (port_model.xfer_open && port_model.byte_position < 2) begin
                    res.read_byte = (port_model.byte_position == 0) ?
                                    port_model.xfer_word[7:0] : port_model.xfer_word[15:8];
                    port_model.byte_position = port_model.byte_position + 2'd1;
                end
                word_done = port_model.xfer_open && port_model.byte_position >= 2;
            end
            CMD_STOP: begin
                // A transfer that moved a byte is dropped; an untouched one survives.
                port_model.expect_register = 1'b1;
                if (port_model.xfer_open && port_model.byte_position > 0) begin
                    port_model.xfer_open = 1'b0;
                    port_model.byte_position = 2'd0;
                    port_model.xfer_word = 16'h0000;
                    port_model.xfer_register = 8'h00;
                end
            end
            default: port_model.intr_asserted = 1'b1;
        endcase

        // A complete word acts on its register and closes the transfer.
        if (word_done) begin
            case (port_model.xfer_register)
                SEL_INPUTS: begin
                    if (inputs_now == port_model.xfer_word) begin
                        port_model.intr_asserted = 1'b0;
                    end
                end
                SEL_RESET: begin
                    res.reset_pulse = 1'b1;
                    port_model.intr_asserted = 1'b0;
                end
                SEL_OUTPUTS: begin
                    if (int'(port_model.xfer_word[15:8]) >= OUT_CHANNELS) begin
                        res.error_code = ERR_OUT_RANGE;
                    end else begin
                        res.out_write = 1'b1;
                        res.out_index = port_model.xfer_word[11:8];
                        res.out_value = port_model.xfer_word[7:0];
                    end
                end
                default: ;
            endcase
            port_model.xfer_open = 1'b0;
            port_model.byte_position = 2'd0;
            port_model.xfer_word = 16'h0000;
            port_model.xfer_register = 8'h00;
        end
        res.intr_level = port_model.intr_asserted;
        return res;
    endfunction

    // Offers one bus event, waits for it to be taken and records its expected result.
    task automatic send_event(cmd_t cmd, logic [7:0] rx, logic [15:0] inputs_now,
                              logic [15:0] temp_raw);
        int gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {temp_raw, inputs_now, rx};
        s_tuser <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_bus_event(cmd, rx, inputs_now, temp_raw));
        events_sent++;
    endtask

    // Short form for events whose inputs and temperature do not matter.
    task automatic send_simple(cmd_t cmd, logic [7:0] rx);
        send_event(cmd, rx, live_inputs, 16'($urandom_range(0, 16'hffff)));
    endtask

    // Reads without a transfer, and the interrupt set and released through the inputs word.
    task automatic test_reads_and_interrupt();
        send_event(CMD_READ, 8'h00, 16'h0000, 16'h0000);
        send_event(CMD_CHANGED, 8'h00, 16'h1234, 16'h0000);
        send_event(CMD_BYTE, SEL_INPUTS, 16'h1234, 16'h0000);
        send_event(CMD_READ, 8'h00, 16'h1234, 16'h0000);
        send_event(CMD_READ, 8'h00, 16'h1234, 16'h0000);
        send_event(CMD_CHANGED, 8'h00, 16'hffff, 16'hffff);
        // Inputs changed again before the word completed, so the line stays asserted.
        send_event(CMD_BYTE, SEL_INPUTS, 16'hffff, 16'hffff);
        send_event(CMD_READ, 8'h00, 16'hffff, 16'hffff);
        send_event(CMD_READ, 8'h00, 16'h0000, 16'hffff);
    endtask

    // Outputs writes at the edges of the index range and the reset register.
    task automatic test_register_writes();
        send_simple(CMD_BYTE, SEL_OUTPUTS);
        send_simple(CMD_BYTE, 8'hff);
        send_simple(CMD_BYTE, 8'h0f);
        send_simple(CMD_BYTE, SEL_OUTPUTS);
        send_simple(CMD_BYTE, 8'h00);
        send_simple(CMD_BYTE, 8'h10);
        send_simple(CMD_BYTE, SEL_OUTPUTS);
        send_simple(CMD_READ, 8'h00);
        send_simple(CMD_BYTE, 8'hff);
        // Reset register with one read and one written byte.
        send_simple(CMD_BYTE, SEL_RESET);
        send_simple(CMD_READ, 8'h00);
        send_simple(CMD_BYTE, 8'h00);
    endtask

    // Unknown registers, STOP in and before a word, and the temperature sample.
    task automatic test_transfer_edges();
        send_simple(CMD_BYTE, 8'hff);
        send_simple(CMD_BYTE, 8'h00);
        send_simple(CMD_BYTE, 8'h00);
        send_simple(CMD_BYTE, SEL_CHECK);
        send_simple(CMD_READ, 8'h00);
        send_simple(CMD_STOP, 8'h00);
        send_simple(CMD_READ, 8'h00);
        send_event(CMD_BYTE, SEL_TEMP, 16'h0000, 16'hffff);
        send_simple(CMD_STOP, 8'h00);
        send_simple(CMD_READ, 8'h00);
        send_simple(CMD_READ, 8'h00);
    endtask

    // One event of the random part; the inputs word drifts now and then.
    task automatic send_random_event(cmd_t cmd, logic [7:0] rx);
        if ($urandom_range(0, 99) < 5) begin
            live_inputs = 16'($urandom_range(0, 16'hffff));
        end
        send_event(cmd, rx, live_inputs, 16'($urandom_range(0, 16'hffff)));
    endtask

    // Mostly well-formed register transfers with random content, plus noise.
    task automatic send_random_transaction();
        logic [7:0] reg_sel;
        logic [7:0] data;
        int         pos;
        if ($urandom_range(0, 99) < 10) begin
            send_random_event(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 99) < 70) begin
            send_random_event(CMD_STOP, 8'($urandom_range(0, 255)));
        end
        reg_sel = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 5))
                                               : 8'($urandom_range(0, 255));
        send_random_event(CMD_BYTE, reg_sel);
        for (pos = 0; pos < 2; pos++) begin
            if ($urandom_range(0, 99) < 10) begin
                live_inputs = 16'($urandom_range(0, 16'hffff));
                send_random_event(CMD_CHANGED, 8'($urandom_range(0, 255)));
            end
            // A STOP here breaks the transfer off.
            if ($urandom_range(0, 99) < 6) begin
                send_random_event(CMD_STOP, 8'($urandom_range(0, 255)));
                return;
            end
            if ($urandom_range(0, 99) < 40) begin
                send_random_event(CMD_READ, 8'($urandom_range(0, 255)));
            end else begin
                data = 8'($urandom_range(0, 255));
                // Keep most output indexes in range.
                if (pos == 1 && $urandom_range(0, 99) < 75) begin
                    data = 8'($urandom_range(0, OUT_CHANNELS - 1));
                end
                send_random_event(CMD_BYTE, data);
            end
        end
    endtask

    // Random transfers under varying idling, including a stretch with none.
    task automatic test_random_traffic();
        tx_gap_pct = 30;
        rx_stall_pct = 30;
        while (events_sent < 250) send_random_transaction();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        while (events_sent < 350) send_random_transaction();
        tx_gap_pct = 50;
        rx_stall_pct = 50;
        while (events_sent < RANDOM_TARGET) send_random_transaction();
    endtask

    // The result side holds off while events keep coming, so the input side stalls.
    task automatic test_backpressure();
        int n;
        tx_gap_pct = 0;
        rx_stall_pct = 10;
        hold_request = 1'b1;
        for (n = 0; n < 40; n++) send_random_transaction();
    endtask

    // Result side: random stalls, and one long hold-off when a test asks for it.
    initial begin : result_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < rx_stall_pct) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Reports a mismatch in one field of a result word.
    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each result word taken with the oldest expectation.
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(result_t)-1:0];
            if (pending_results.size() == 0) begin
                $error("result word 0x%0h arrived with none expected", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("read_byte", want.read_byte, got.read_byte);
                check_field("intr_level", 8'(want.intr_level), 8'(got.intr_level));
                check_field("reset_pulse", 8'(want.reset_pulse), 8'(got.reset_pulse));
                check_field("out_write", 8'(want.out_write), 8'(got.out_write));
                check_field("out_index", 8'(want.out_index), 8'(got.out_index));
                check_field("out_value", want.out_value, got.out_value);
                check_field("error_code", 8'(want.error_code), 8'(got.error_code));
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("i2c_target_word_register_port: mismatch");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        port_model = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reads_and_interrupt();
        test_register_writes();
        test_transfer_edges();
        test_random_traffic();
        test_backpressure();
        s_tvalid <= 1'b0;

        // Let the last results drain, then watch for stray words.
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("i2c_target_word_register_port: match");
        end else begin
            $display("i2c_target_word_register_port: mismatch");
        end
        $finish;
    end

endmodule
